FILE: sv/bea_pkg.sv
// shared types and constants for the button edge / autorepeat / pointer block
`timescale 1ns / 1ps

package bea_pkg;

    localparam int BUTTONS_W = 25;
    localparam int ELAPSED_W = 16;
    localparam int MOVE_W    = 16;
    localparam int POS_W     = 12;
    localparam int DELAY_W   = 16;
    localparam int DIM_W     = 13;
    localparam int COUNT_W   = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int SUM_W     = 18;

    localparam logic [DIM_W-1:0] DISPLAY_W_RESET = 13'd640;
    localparam logic [DIM_W-1:0] DISPLAY_H_RESET = 13'd480;
    localparam logic [DIM_W-1:0] DIM_LIMIT_MAX   = 13'd4096;
    localparam logic [DIM_W-1:0] DIM_LIMIT_MIN   = 13'd1;

    typedef enum logic [1:0] {
        REG_FIRST_DELAY    = 2'd0,
        REG_REPEAT_PERIOD  = 2'd1,
        REG_DISPLAY_WIDTH  = 2'd2,
        REG_DISPLAY_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [BUTTONS_W-1:0]     button_levels;
        logic [ELAPSED_W-1:0]     elapsed_ms;
        logic                     pointer_present;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } t_in_item;

    typedef struct packed {
        logic [BUTTONS_W-1:0] held_mask;
        logic [BUTTONS_W-1:0] trigger_mask;
        logic [BUTTONS_W-1:0] repeat_mask;
        logic [POS_W-1:0]     pointer_x;
        logic [POS_W-1:0]     pointer_y;
    } t_out_item;

    typedef struct packed {
        logic [DELAY_W-1:0] first_delay;
        logic [DELAY_W-1:0] repeat_period;
        logic [DIM_W-1:0]   display_width;
        logic [DIM_W-1:0]   display_height;
    } t_cfg;

endpackage

FILE: sv/bea_regs.sv
// apb configuration registers
`timescale 1ns / 1ps

module bea_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bea_pkg::ADDR_W-1:0]   paddr,
    input  logic [bea_pkg::DATA_W-1:0]   pwdata,
    output logic [bea_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output bea_pkg::t_cfg                o_cfg
);

    bea_pkg::t_cfg    r_cfg;
    bea_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = bea_pkg::t_reg_idx'(paddr[bea_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_delay    <= '0;
            r_cfg.repeat_period  <= '0;
            r_cfg.display_width  <= bea_pkg::DISPLAY_W_RESET;
            r_cfg.display_height <= bea_pkg::DISPLAY_H_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                bea_pkg::REG_FIRST_DELAY: begin
                    r_cfg.first_delay <= pwdata[bea_pkg::DELAY_W-1:0];
                end
                bea_pkg::REG_REPEAT_PERIOD: begin
                    r_cfg.repeat_period <= pwdata[bea_pkg::DELAY_W-1:0];
                end
                bea_pkg::REG_DISPLAY_WIDTH: begin
                    r_cfg.display_width <= pwdata[bea_pkg::DIM_W-1:0];
                end
                bea_pkg::REG_DISPLAY_HEIGHT: begin
                    r_cfg.display_height <= pwdata[bea_pkg::DIM_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bea_pkg::REG_FIRST_DELAY:
                prdata = bea_pkg::DATA_W'(r_cfg.first_delay);
            bea_pkg::REG_REPEAT_PERIOD:
                prdata = bea_pkg::DATA_W'(r_cfg.repeat_period);
            bea_pkg::REG_DISPLAY_WIDTH:
                prdata = bea_pkg::DATA_W'(r_cfg.display_width);
            bea_pkg::REG_DISPLAY_HEIGHT:
                prdata = bea_pkg::DATA_W'(r_cfg.display_height);
        endcase
    end

endmodule

FILE: sv/bea_engine.sv
// per-poll state and result logic: edges, typematic repeat, pointer clamp
`timescale 1ns / 1ps

module bea_engine #(
    parameter int BUTTON_COUNT = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  bea_pkg::t_in_item    i_item,
    input  bea_pkg::t_cfg        i_cfg,
    output bea_pkg::t_out_item   o_result
);

    localparam logic [bea_pkg::BUTTONS_W-1:0] BTN_MASK =
        bea_pkg::BUTTONS_W'((64'd1 << BUTTON_COUNT) - 64'd1);

    logic [bea_pkg::BUTTONS_W-1:0] r_prev_buttons, n_prev_buttons;
    logic [bea_pkg::COUNT_W-1:0]   r_elapsed, n_elapsed;
    logic [bea_pkg::DELAY_W-1:0]   r_delay, n_delay;
    logic [bea_pkg::POS_W-1:0]     r_pos_x, n_pos_x;
    logic [bea_pkg::POS_W-1:0]     r_pos_y, n_pos_y;

    logic [bea_pkg::BUTTONS_W-1:0] w_held, w_trigger, w_repeat;
    logic [bea_pkg::COUNT_W:0]     w_sum;
    logic [bea_pkg::COUNT_W-1:0]   w_acc;
    logic                          w_rep_en, w_fire;

    // add a signed move and clamp into [0, limit-1]
    function automatic logic [bea_pkg::POS_W-1:0] clamp_move(
        input logic [bea_pkg::POS_W-1:0]     pos,
        input logic signed [bea_pkg::MOVE_W-1:0] mv,
        input logic [bea_pkg::DIM_W-1:0]     dim
    );
        logic [bea_pkg::DIM_W-1:0]        lim;
        logic signed [bea_pkg::SUM_W-1:0] sum;
        logic [bea_pkg::POS_W-1:0]        res;
        lim = dim;
        if (dim == '0) begin
            lim = bea_pkg::DIM_LIMIT_MIN;
        end else if (dim > bea_pkg::DIM_LIMIT_MAX) begin
            lim = bea_pkg::DIM_LIMIT_MAX;
        end
        sum = $signed({{(bea_pkg::SUM_W-bea_pkg::POS_W){1'b0}}, pos})
            + $signed({{(bea_pkg::SUM_W-bea_pkg::MOVE_W){mv[bea_pkg::MOVE_W-1]}}, mv});
        if (sum < 0) begin
            res = '0;
        end else if (sum >= $signed({{(bea_pkg::SUM_W-bea_pkg::DIM_W){1'b0}}, lim})) begin
            res = bea_pkg::POS_W'(lim - bea_pkg::DIM_LIMIT_MIN);
        end else begin
            res = sum[bea_pkg::POS_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        w_held    = i_item.button_levels & BTN_MASK;
        w_trigger = w_held & ~r_prev_buttons;
        w_rep_en  = (i_cfg.repeat_period != '0);

        // saturating elapsed counter
        w_sum = {1'b0, r_elapsed} + (bea_pkg::COUNT_W + 1)'(i_item.elapsed_ms);
        w_acc = w_sum[bea_pkg::COUNT_W] ? '1 : w_sum[bea_pkg::COUNT_W-1:0];

        n_elapsed = w_acc;
        n_delay   = r_delay;
        w_fire    = 1'b0;
        if (w_rep_en) begin
            if (w_trigger != '0) begin
                n_delay   = i_cfg.first_delay;
                w_fire    = 1'b1;
                n_elapsed = '0;
            end else if (w_held != '0 &&
                         w_acc >= bea_pkg::COUNT_W'(r_delay)) begin
                n_delay   = i_cfg.repeat_period;
                w_fire    = 1'b1;
                n_elapsed = '0;
            end
        end
        w_repeat = (!w_rep_en || w_fire) ? w_held : '0;

        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (i_item.pointer_present) begin
            n_pos_x = clamp_move(r_pos_x, i_item.move_x, i_cfg.display_width);
            n_pos_y = clamp_move(r_pos_y, i_item.move_y, i_cfg.display_height);
        end
        n_prev_buttons = w_held;

        o_result.held_mask    = w_held;
        o_result.trigger_mask = w_trigger;
        o_result.repeat_mask  = w_repeat;
        o_result.pointer_x    = n_pos_x;
        o_result.pointer_y    = n_pos_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_elapsed      <= '0;
            r_delay        <= '0;
            r_pos_x        <= '0;
            r_pos_y        <= '0;
        end else if (i_step) begin
            r_prev_buttons <= n_prev_buttons;
            r_elapsed      <= n_elapsed;
            r_delay        <= n_delay;
            r_pos_x        <= n_pos_x;
            r_pos_y        <= n_pos_y;
        end
    end

endmodule

FILE: sv/button_edge_autorepeat_pointer.sv
// top level: poll input register, per-poll engine, result register, apb registers
`timescale 1ns / 1ps

// an accepted poll waits in the input register, then passes through the engine into the
//   result register, which presents it to the result transaction
// throughput: one poll per clock while the result side does not stall; the input register
//   refills in the same cycle the engine moves its poll into the result register
// the input side stalls only while both registers hold a transaction and the
//   result side stalls
// reset (synchronous, active low) empties both registers, clears the button,
//   elapsed, delay and pointer state and loads the register reset values
module button_edge_autorepeat_pointer #(
    parameter int BUTTON_COUNT = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // poll input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bea_pkg::t_in_item           i_in_data,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bea_pkg::t_out_item          o_out_data,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bea_pkg::ADDR_W-1:0]  paddr,
    input  logic [bea_pkg::DATA_W-1:0]  pwdata,
    output logic [bea_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    bea_pkg::t_cfg      w_cfg;
    bea_pkg::t_in_item  r_in_item;
    bea_pkg::t_out_item r_out_item, w_result;
    logic               r_in_valid, n_in_valid;
    logic               r_out_valid, n_out_valid;
    logic               w_in_accept, w_advance;

    // register file
    bea_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // state advances only when the held poll moves into the result register
    bea_engine #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // the held poll moves on when the result slot is empty or being drained
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_data;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // a new press is always also a held button
    a_trigger_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.trigger_mask & ~o_out_data.held_mask) == '0))
        else $error("trigger mask has a bit outside the held mask");

    // repeat fires for all held buttons or none
    a_repeat_all_or_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.repeat_mask == '0 ||
                         o_out_data.repeat_mask == o_out_data.held_mask))
        else $error("repeat mask is neither zero nor the held mask");

    // a poll leaving the input register always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register empty after an advance");

    // input stalls only when both stages are full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule
